@@ rtl/bsc_pkg.sv @@
// Shared constants, types, sweep coefficient tables and codes for the Bezier spline block.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int COORD_W    = 32;
  localparam int IDXW       = $clog2(MAX_POINTS);
  localparam int CNTW       = $clog2(MAX_POINTS + 1);
  localparam int SW_DEPTH   = 3 * MAX_POINTS;
  localparam int SWAW       = $clog2(SW_DEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [43:0]        wide_t;
  typedef logic signed [39:0]        op_t;

  localparam logic [1:0] KIND_PT = 2'd0;
  localparam logic [1:0] KIND_A  = 2'd1;
  localparam logic [1:0] KIND_B  = 2'd2;

  typedef enum logic [5:0] {
    ST_LOAD, ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
    ST_F0, ST_F1, ST_F2, ST_FL0, ST_FL1, ST_FL2,
    ST_L0, ST_L1, ST_L2, ST_B0, ST_B1, ST_B2,
    ST_MLO, ST_MHI,
    ST_O0, ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6,
    ST_O7, ST_O8, ST_O9, ST_O10, ST_O11, ST_O12,
    ST_EMIT, ST_FIN
  } state_t;

  localparam logic [63:0] ONE60 = 64'd1 << 60;
  localparam logic [63:0] D4    = 64'd4 << 30;
  localparam logic [63:0] D7    = 64'd7 << 30;

  localparam logic [63:0] CF0  = 64'd1 << 29;
  localparam logic [63:0] CF1  = (ONE60 + (D4 - CF0)  / 2) / (D4 - CF0);
  localparam logic [63:0] CF2  = (ONE60 + (D4 - CF1)  / 2) / (D4 - CF1);
  localparam logic [63:0] CF3  = (ONE60 + (D4 - CF2)  / 2) / (D4 - CF2);
  localparam logic [63:0] CF4  = (ONE60 + (D4 - CF3)  / 2) / (D4 - CF3);
  localparam logic [63:0] CF5  = (ONE60 + (D4 - CF4)  / 2) / (D4 - CF4);
  localparam logic [63:0] CF6  = (ONE60 + (D4 - CF5)  / 2) / (D4 - CF5);
  localparam logic [63:0] CF7  = (ONE60 + (D4 - CF6)  / 2) / (D4 - CF6);
  localparam logic [63:0] CF8  = (ONE60 + (D4 - CF7)  / 2) / (D4 - CF7);
  localparam logic [63:0] CF9  = (ONE60 + (D4 - CF8)  / 2) / (D4 - CF8);
  localparam logic [63:0] CF10 = (ONE60 + (D4 - CF9)  / 2) / (D4 - CF9);
  localparam logic [63:0] CF11 = (ONE60 + (D4 - CF10) / 2) / (D4 - CF10);
  localparam logic [63:0] CF12 = (ONE60 + (D4 - CF11) / 2) / (D4 - CF11);
  localparam logic [63:0] CF13 = (ONE60 + (D4 - CF12) / 2) / (D4 - CF12);
  localparam logic [63:0] CF14 = (ONE60 + (D4 - CF13) / 2) / (D4 - CF13);

  localparam logic [63:0] RL0  = (ONE60 + (D7 - 2 * CF0)  / 2) / (D7 - 2 * CF0);
  localparam logic [63:0] RL1  = (ONE60 + (D7 - 2 * CF1)  / 2) / (D7 - 2 * CF1);
  localparam logic [63:0] RL2  = (ONE60 + (D7 - 2 * CF2)  / 2) / (D7 - 2 * CF2);
  localparam logic [63:0] RL3  = (ONE60 + (D7 - 2 * CF3)  / 2) / (D7 - 2 * CF3);
  localparam logic [63:0] RL4  = (ONE60 + (D7 - 2 * CF4)  / 2) / (D7 - 2 * CF4);
  localparam logic [63:0] RL5  = (ONE60 + (D7 - 2 * CF5)  / 2) / (D7 - 2 * CF5);
  localparam logic [63:0] RL6  = (ONE60 + (D7 - 2 * CF6)  / 2) / (D7 - 2 * CF6);
  localparam logic [63:0] RL7  = (ONE60 + (D7 - 2 * CF7)  / 2) / (D7 - 2 * CF7);
  localparam logic [63:0] RL8  = (ONE60 + (D7 - 2 * CF8)  / 2) / (D7 - 2 * CF8);
  localparam logic [63:0] RL9  = (ONE60 + (D7 - 2 * CF9)  / 2) / (D7 - 2 * CF9);
  localparam logic [63:0] RL10 = (ONE60 + (D7 - 2 * CF10) / 2) / (D7 - 2 * CF10);
  localparam logic [63:0] RL11 = (ONE60 + (D7 - 2 * CF11) / 2) / (D7 - 2 * CF11);
  localparam logic [63:0] RL12 = (ONE60 + (D7 - 2 * CF12) / 2) / (D7 - 2 * CF12);
  localparam logic [63:0] RL13 = (ONE60 + (D7 - 2 * CF13) / 2) / (D7 - 2 * CF13);
  localparam logic [63:0] RL14 = (ONE60 + (D7 - 2 * CF14) / 2) / (D7 - 2 * CF14);

  function automatic logic [31:0] coef_at(input logic [IDXW-1:0] i);
    logic [63:0] c;
    case (i)
      0:       c = CF0;
      1:       c = CF1;
      2:       c = CF2;
      3:       c = CF3;
      4:       c = CF4;
      5:       c = CF5;
      6:       c = CF6;
      7:       c = CF7;
      8:       c = CF8;
      9:       c = CF9;
      10:      c = CF10;
      11:      c = CF11;
      12:      c = CF12;
      13:      c = CF13;
      14:      c = CF14;
      default: c = '0;
    endcase
    return c[31:0];
  endfunction

  function automatic logic [31:0] rlast_at(input logic [IDXW-1:0] i);
    logic [63:0] c;
    case (i)
      0:       c = RL0;
      1:       c = RL1;
      2:       c = RL2;
      3:       c = RL3;
      4:       c = RL4;
      5:       c = RL5;
      6:       c = RL6;
      7:       c = RL7;
      8:       c = RL8;
      9:       c = RL9;
      10:      c = RL10;
      11:      c = RL11;
      12:      c = RL12;
      13:      c = RL13;
      14:      c = RL14;
      default: c = '0;
    endcase
    return c[31:0];
  endfunction

endpackage

@@ rtl/bsc_if.sv @@
// Request channel interfaces for input points and output control points.
`timescale 1ns / 1ps
interface bsc_in_if;
  import bsc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface bsc_out_if;
  import bsc_pkg::*;
  logic       valid;
  logic       ready;
  coord_t     ctrl_x;
  coord_t     ctrl_y;
  coord_t     ctrl_z;
  logic [1:0] point_kind;
  logic       overflow;
  logic       last_out;
  modport source (output valid, ctrl_x, ctrl_y, ctrl_z, point_kind, overflow, last_out,
                  input ready);
  modport sink   (input valid, ctrl_x, ctrl_y, ctrl_z, point_kind, overflow, last_out,
                  output ready);
endinterface

@@ rtl/bsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bsc_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bezier_spline_control_points.sv @@
// Top level: point store, per-axis tridiagonal solver and control point sequencer.
// Points load one per cycle while in_ch.ready is high; the point that carries last_point
// closes the set and the block drops ready until the last control point of the run is
// taken. For n+1 points (n >= 2) the solve runs on the three axes in turn, then the
// output runs segment by segment. One 20x32 multiplier, used for a low half and then a
// high half of each product, and the single read port of the working store set the pace.
// Two points give four results straight from the store; a lone point gives none. Points
// past 16 are dropped and flagged on every result of the run.
`timescale 1ns / 1ps
module bezier_spline_control_points (
  input logic     clk,
  input logic     rst_n,
  bsc_in_if.sink  in_ch,
  bsc_out_if.source out_ch
);
  import bsc_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  state_t emit_ret_r, emit_ret_nxt;

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [IDXW-1:0] nseg_r, nseg_nxt;
  logic [IDXW-1:0] idx_r, idx_nxt;
  logic [1:0]      axis_r, axis_nxt;
  coord_t          p_cur_r, p_cur_nxt;
  coord_t          tmp_r, tmp_nxt;
  coord_t          d_prev_r, d_prev_nxt;
  coord_t          a_r, a_nxt;
  op_t             op_r, op_nxt;
  logic [31:0]     coef_r, coef_nxt;
  logic [71:0]     acc_r, acc_nxt;
  coord_t          ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic            last_r, last_nxt;

  logic                       pt_we;
  logic [IDXW-1:0]            pt_ra;
  logic [3*COORD_W-1:0]       pt_rd;
  logic                       sw_we;
  logic [SWAW-1:0]            sw_wa, sw_ra;
  coord_t                     sw_wd;
  logic [COORD_W-1:0]         sw_rd;

  logic            in_acc;
  logic            keep;
  logic [CNTW-1:0] total, total_m1;
  logic [CNTW-1:0] idx_p1, idx_p2, nseg_w;
  logic [IDXW-1:0] jb;
  logic            b_last;
  logic [39:0]     mag;
  logic [19:0]     mul_a;
  logic [51:0]     mul_p;
  logic [71:0]     rnd;
  logic [41:0]     rmag;
  wide_t           mres;

  function automatic coord_t pick(input logic [3*COORD_W-1:0] w, input logic [1:0] ax);
    coord_t v;
    case (ax)
      2'd0:    v = w[COORD_W-1:0];
      2'd1:    v = w[2*COORD_W-1:COORD_W];
      default: v = w[3*COORD_W-1:2*COORD_W];
    endcase
    return v;
  endfunction

  function automatic wide_t ext(input coord_t p);
    return wide_t'(p);
  endfunction

  function automatic coord_t sat32(input wide_t v);
    coord_t r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic wide_t half_rnd(input wide_t v);
    wide_t r;
    if (v >= 0) begin
      r = (v + 44'sd1) >>> 1;
    end else begin
      r = -((-v + 44'sd1) >>> 1);
    end
    return r;
  endfunction

  function automatic logic [SWAW-1:0] sw_addr(input logic [1:0] ax, input logic [IDXW-1:0] i);
    return SWAW'(ax) * SWAW'(MAX_POINTS) + SWAW'(i);
  endfunction

  function automatic coord_t b_val(input coord_t p, input coord_t a, input logic lst);
    coord_t r;
    if (lst) begin
      r = sat32(half_rnd(ext(a) + ext(p)));
    end else begin
      r = sat32(2 * ext(p) - ext(a));
    end
    return r;
  endfunction

  bsc_ram #(.W(3 * COORD_W), .D(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt_r[IDXW-1:0]),
    .wdata ({in_ch.point_z, in_ch.point_y, in_ch.point_x}),
    .raddr (pt_ra),
    .rdata (pt_rd)
  );

  bsc_ram #(.W(COORD_W), .D(SW_DEPTH)) u_sw_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (sw_wa),
    .wdata (sw_wd),
    .raddr (sw_ra),
    .rdata (sw_rd)
  );

  assign in_ch.ready       = (state_r == ST_LOAD);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = (state_r == ST_EMIT);
  assign out_ch.ctrl_x     = ox_r;
  assign out_ch.ctrl_y     = oy_r;
  assign out_ch.ctrl_z     = oz_r;
  assign out_ch.point_kind = kind_r;
  assign out_ch.overflow   = ovf_r;
  assign out_ch.last_out   = last_r;

  assign keep     = (cnt_r < CNTW'(MAX_POINTS));
  assign total    = cnt_r + CNTW'(keep);
  assign total_m1 = total - CNTW'(1);
  assign idx_p1   = CNTW'(idx_r) + CNTW'(1);
  assign idx_p2   = CNTW'(idx_r) + CNTW'(2);
  assign nseg_w   = CNTW'(nseg_r);
  assign b_last   = !(idx_p1 < nseg_w);
  assign jb       = b_last ? idx_r : idx_p1[IDXW-1:0];

  // shared multiplier: magnitude times Q2.30 coefficient, low half then high half
  assign mag   = op_r[39] ? $unsigned(-op_r) : $unsigned(op_r);
  assign mul_a = (state_r == ST_MHI) ? mag[39:20] : mag[19:0];
  assign mul_p = 52'(mul_a) * 52'(coef_r);
  assign rnd   = acc_r + (72'd1 << 29);
  assign rmag  = rnd[71:30];
  assign mres  = op_r[39] ? -$signed({2'b00, rmag}) : $signed({2'b00, rmag});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc && in_ch.last_point) begin
          if (total == CNTW'(2)) begin
            state_nxt = ST_T0;
          end else if (total > CNTW'(2)) begin
            state_nxt = ST_F0;
          end
        end
      end
      ST_T0:   state_nxt = ST_T1;
      ST_T1:   state_nxt = ST_EMIT;
      ST_T2:   state_nxt = ST_EMIT;
      ST_T3:   state_nxt = ST_T4;
      ST_T4:   state_nxt = ST_EMIT;
      ST_T5:   state_nxt = ST_EMIT;
      ST_F0:   state_nxt = ST_F1;
      ST_F1:   state_nxt = ST_F2;
      ST_F2:   state_nxt = (nseg_w > CNTW'(2)) ? ST_FL0 : ST_L0;
      ST_FL0:  state_nxt = ST_FL1;
      ST_FL1:  state_nxt = ST_MLO;
      ST_FL2:  state_nxt = (idx_p2 < nseg_w) ? ST_FL0 : ST_L0;
      ST_L0:   state_nxt = ST_L1;
      ST_L1:   state_nxt = ST_MLO;
      ST_L2:   state_nxt = ST_B0;
      ST_B0:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_MLO;
      ST_B2: begin
        if (idx_r == IDXW'(1)) begin
          state_nxt = (axis_r == 2'd2) ? ST_O0 : ST_F0;
        end else begin
          state_nxt = ST_B0;
        end
      end
      ST_MLO:  state_nxt = ST_MHI;
      ST_MHI:  state_nxt = ret_r;
      ST_O0:   state_nxt = ST_O1;
      ST_O1:   state_nxt = ST_EMIT;
      ST_O2:   state_nxt = ST_O3;
      ST_O3:   state_nxt = ST_O4;
      ST_O4:   state_nxt = ST_O5;
      ST_O5:   state_nxt = ST_EMIT;
      ST_O6:   state_nxt = ST_O7;
      ST_O7:   state_nxt = ST_O8;
      ST_O8:   state_nxt = ST_O9;
      ST_O9:   state_nxt = ST_EMIT;
      ST_O10:  state_nxt = (idx_p1 < nseg_w) ? ST_O0 : ST_O11;
      ST_O11:  state_nxt = ST_O12;
      ST_O12:  state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = out_ch.ready ? emit_ret_r : ST_EMIT;
      ST_FIN:  state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    ret_nxt      = ret_r;
    emit_ret_nxt = emit_ret_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    nseg_nxt     = nseg_r;
    idx_nxt      = idx_r;
    axis_nxt     = axis_r;
    p_cur_nxt    = p_cur_r;
    tmp_nxt      = tmp_r;
    d_prev_nxt   = d_prev_r;
    a_nxt        = a_r;
    op_nxt       = op_r;
    coef_nxt     = coef_r;
    acc_nxt      = acc_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    oz_nxt       = oz_r;
    kind_nxt     = kind_r;
    last_nxt     = last_r;
    pt_we        = 1'b0;
    pt_ra        = '0;
    sw_we        = 1'b0;
    sw_wa        = '0;
    sw_wd        = '0;
    sw_ra        = '0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (keep) begin
            pt_we   = 1'b1;
            cnt_nxt = total;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_point) begin
            nseg_nxt = total_m1[IDXW-1:0];
            axis_nxt = 2'd0;
            last_nxt = 1'b0;
            if (total < CNTW'(2)) begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end
          end
        end
      end
      ST_T0: pt_ra = IDXW'(0);
      ST_T1: begin
        ox_nxt       = pick(pt_rd, 2'd0);
        oy_nxt       = pick(pt_rd, 2'd1);
        oz_nxt       = pick(pt_rd, 2'd2);
        kind_nxt     = KIND_PT;
        emit_ret_nxt = ST_T2;
      end
      ST_T2: begin
        kind_nxt     = KIND_A;
        emit_ret_nxt = ST_T3;
      end
      ST_T3: pt_ra = IDXW'(1);
      ST_T4: begin
        ox_nxt       = pick(pt_rd, 2'd0);
        oy_nxt       = pick(pt_rd, 2'd1);
        oz_nxt       = pick(pt_rd, 2'd2);
        kind_nxt     = KIND_B;
        emit_ret_nxt = ST_T5;
      end
      ST_T5: begin
        kind_nxt     = KIND_PT;
        last_nxt     = 1'b1;
        emit_ret_nxt = ST_FIN;
      end
      ST_F0: pt_ra = IDXW'(0);
      ST_F1: begin
        tmp_nxt = pick(pt_rd, axis_r);
        pt_ra   = IDXW'(1);
      end
      ST_F2: begin
        p_cur_nxt  = pick(pt_rd, axis_r);
        d_prev_nxt = sat32(half_rnd(ext(tmp_r) + 2 * ext(pick(pt_rd, axis_r))));
        sw_we      = 1'b1;
        sw_wa      = sw_addr(axis_r, IDXW'(0));
        sw_wd      = d_prev_nxt;
        idx_nxt    = IDXW'(1);
      end
      ST_FL0: pt_ra = idx_p1[IDXW-1:0];
      ST_FL1: begin
        op_nxt    = op_t'(2 * (2 * ext(p_cur_r) + ext(pick(pt_rd, axis_r))) - ext(d_prev_r));
        coef_nxt  = coef_at(idx_r);
        p_cur_nxt = pick(pt_rd, axis_r);
        ret_nxt   = ST_FL2;
      end
      ST_FL2: begin
        d_prev_nxt = sat32(mres);
        sw_we      = 1'b1;
        sw_wa      = sw_addr(axis_r, idx_r);
        sw_wd      = d_prev_nxt;
        idx_nxt    = idx_p1[IDXW-1:0];
      end
      ST_L0: pt_ra = idx_p1[IDXW-1:0];
      ST_L1: begin
        op_nxt   = op_t'(8 * ext(p_cur_r) + ext(pick(pt_rd, axis_r)) - 2 * ext(d_prev_r));
        coef_nxt = rlast_at(nseg_r - IDXW'(2));
        ret_nxt  = ST_L2;
      end
      ST_L2: begin
        a_nxt = sat32(mres);
        sw_we = 1'b1;
        sw_wa = sw_addr(axis_r, idx_r);
        sw_wd = a_nxt;
      end
      ST_B0: sw_ra = sw_addr(axis_r, idx_r - IDXW'(1));
      ST_B1: begin
        tmp_nxt  = sw_rd;
        op_nxt   = op_t'(ext(a_r));
        coef_nxt = coef_at(idx_r - IDXW'(1));
        ret_nxt  = ST_B2;
      end
      ST_B2: begin
        a_nxt   = sat32(ext(tmp_r) - mres);
        sw_we   = 1'b1;
        sw_wa   = sw_addr(axis_r, idx_r - IDXW'(1));
        sw_wd   = a_nxt;
        idx_nxt = idx_r - IDXW'(1);
        if (idx_r == IDXW'(1) && axis_r != 2'd2) begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      ST_MLO: acc_nxt = 72'(mul_p);
      ST_MHI: acc_nxt = acc_r + (72'(mul_p) << 20);
      ST_O0: pt_ra = idx_r;
      ST_O1: begin
        ox_nxt       = pick(pt_rd, 2'd0);
        oy_nxt       = pick(pt_rd, 2'd1);
        oz_nxt       = pick(pt_rd, 2'd2);
        kind_nxt     = KIND_PT;
        emit_ret_nxt = ST_O2;
      end
      ST_O2: sw_ra = sw_addr(2'd0, idx_r);
      ST_O3: begin
        ox_nxt = sw_rd;
        sw_ra  = sw_addr(2'd1, idx_r);
      end
      ST_O4: begin
        oy_nxt = sw_rd;
        sw_ra  = sw_addr(2'd2, idx_r);
      end
      ST_O5: begin
        oz_nxt       = sw_rd;
        kind_nxt     = KIND_A;
        emit_ret_nxt = ST_O6;
      end
      ST_O6: begin
        pt_ra = idx_p1[IDXW-1:0];
        sw_ra = sw_addr(2'd0, jb);
      end
      ST_O7: begin
        pt_ra  = idx_p1[IDXW-1:0];
        ox_nxt = b_val(pick(pt_rd, 2'd0), sw_rd, b_last);
        sw_ra  = sw_addr(2'd1, jb);
      end
      ST_O8: begin
        pt_ra  = idx_p1[IDXW-1:0];
        oy_nxt = b_val(pick(pt_rd, 2'd1), sw_rd, b_last);
        sw_ra  = sw_addr(2'd2, jb);
      end
      ST_O9: begin
        oz_nxt       = b_val(pick(pt_rd, 2'd2), sw_rd, b_last);
        kind_nxt     = KIND_B;
        emit_ret_nxt = ST_O10;
      end
      ST_O10: idx_nxt = idx_p1[IDXW-1:0];
      ST_O11: pt_ra = nseg_r;
      ST_O12: begin
        ox_nxt       = pick(pt_rd, 2'd0);
        oy_nxt       = pick(pt_rd, 2'd1);
        oz_nxt       = pick(pt_rd, 2'd2);
        kind_nxt     = KIND_PT;
        last_nxt     = 1'b1;
        emit_ret_nxt = ST_FIN;
      end
      ST_EMIT: begin
      end
      ST_FIN: begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        last_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r      <= ret_nxt;
    emit_ret_r <= emit_ret_nxt;
    nseg_r     <= nseg_nxt;
    idx_r      <= idx_nxt;
    axis_r     <= axis_nxt;
    p_cur_r    <= p_cur_nxt;
    tmp_r      <= tmp_nxt;
    d_prev_r   <= d_prev_nxt;
    a_r        <= a_nxt;
    op_r       <= op_nxt;
    coef_r     <= coef_nxt;
    acc_r      <= acc_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    oz_r       <= oz_nxt;
    kind_r     <= kind_nxt;
  end

endmodule

@@ rtl/bsc_chk.sv @@
// Port-level checker for the Bezier spline block and its bind.
`timescale 1ns / 1ps
module bsc_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         in_last,
  input logic         out_valid,
  input logic         out_ready,
  input logic [31:0]  ctrl_x,
  input logic [1:0]   point_kind,
  input logic         last_out
);
  import bsc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ctrl_x) && $stable(point_kind))
    else $error("stalled request changed");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and output active together");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_out |=> !out_valid ##1 in_ready)
    else $error("output continued after final request");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (point_kind == KIND_PT || point_kind == KIND_A || point_kind == KIND_B))
    else $error("bad point kind");

  a_load_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("load stopped before final point");

endmodule

bind bezier_spline_control_points bsc_chk u_bsc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_point),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ctrl_x     (out_ch.ctrl_x),
  .point_kind (out_ch.point_kind),
  .last_out   (out_ch.last_out)
);

@@ sim/testbench.sv @@
// Testbench for the Bezier spline control point block: directed and random point sets checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import bsc_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    bit     drain;
  } point_req_t;

  typedef struct {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic [1:0] kind;
    logic       ovf;
    logic       last;
  } ctrl_pt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bsc_in_if  in_ch();
  bsc_out_if out_ch();

  bezier_spline_control_points DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  point_req_t point_q[$];
  ctrl_pt_t   ctrl_q[$];

  longint stored_pt[3][MAX_POINTS];
  longint sweep_val[3][MAX_POINTS];
  longint unsigned sweep_coef[MAX_POINTS];
  int     pt_count = 0;
  bit     pt_overflow = 0;

  int  errors = 0;
  int  acc_in = 0;
  int  acc_out = 0;
  int  sets_done = 0;
  int  ovf_sets = 0;
  int  idle_cnt = 0;
  int  holdoff = 0;
  bit  held = 0;
  bit  in_acc = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint half_rnd(longint v);
    if (v >= 0) return (v + 1) / 2;
    return -((-v + 1) / 2);
  endfunction

  function automatic longint mul_coef(longint a, longint unsigned c);
    longint unsigned m;
    longint unsigned r;
    m = (a < 0) ? longint'(-a) : a;
    r = (m * c + (64'd1 << 29)) >> 30;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned recip_q30(longint unsigned den);
    return ((64'd1 << 60) + den / 2) / den;
  endfunction

  function automatic longint pt_at(int ax, int i);
    if (i >= MAX_POINTS) return 0;
    return stored_pt[ax][i];
  endfunction

  task automatic push_ctrl(longint x, longint y, longint z, logic [1:0] kind, logic last);
    ctrl_pt_t c;
    c.x = coord_t'(x);
    c.y = coord_t'(y);
    c.z = coord_t'(z);
    c.kind = kind;
    c.ovf = pt_overflow;
    c.last = last;
    ctrl_q.insert(ctrl_q.size(), c);
  endtask

  task automatic solve_spline_axis(int ax, int n);
    longint unsigned rl;
    longint k;
    sweep_val[ax][0] = sat32(half_rnd(pt_at(ax, 0) + 2 * pt_at(ax, 1)));
    for (int i = 1; i + 1 < n; i++) begin
      k = 2 * (2 * pt_at(ax, i) + pt_at(ax, i + 1));
      sweep_val[ax][i] = sat32(mul_coef(k - sweep_val[ax][i-1], sweep_coef[i]));
    end
    rl = recip_q30((64'd7 << 30) - 2 * sweep_coef[n-2]);
    sweep_val[ax][n-1] = sat32(mul_coef(8 * pt_at(ax, n - 1) + pt_at(ax, n)
                                        - 2 * sweep_val[ax][n-2], rl));
    for (int i = n - 1; i > 0; i--)
      sweep_val[ax][i-1] = sat32(sweep_val[ax][i-1] - mul_coef(sweep_val[ax][i],
                                                              sweep_coef[i-1]));
  endtask

  function automatic longint inner_b(int ax, int i, int n);
    if (i + 1 < n) return sat32(2 * pt_at(ax, i + 1) - sweep_val[ax][i+1]);
    return sat32(half_rnd(sweep_val[ax][n-1] + pt_at(ax, n)));
  endfunction

  task automatic predict_ctrl_points(coord_t x, coord_t y, coord_t z, logic last);
    int n;
    if (pt_count < MAX_POINTS) begin
      stored_pt[0][pt_count] = longint'(x);
      stored_pt[1][pt_count] = longint'(y);
      stored_pt[2][pt_count] = longint'(z);
      pt_count++;
    end else begin
      pt_overflow = 1;
    end
    if (!last) return;
    if (pt_overflow) ovf_sets++;
    sets_done++;
    if (pt_count == 2) begin
      push_ctrl(pt_at(0, 0), pt_at(1, 0), pt_at(2, 0), KIND_PT, 1'b0);
      push_ctrl(pt_at(0, 0), pt_at(1, 0), pt_at(2, 0), KIND_A, 1'b0);
      push_ctrl(pt_at(0, 1), pt_at(1, 1), pt_at(2, 1), KIND_B, 1'b0);
      push_ctrl(pt_at(0, 1), pt_at(1, 1), pt_at(2, 1), KIND_PT, 1'b1);
    end else if (pt_count > 2) begin
      n = pt_count - 1;
      sweep_coef[0] = 64'd1 << 29;
      for (int i = 1; i < MAX_POINTS; i++)
        sweep_coef[i] = recip_q30((64'd4 << 30) - sweep_coef[i-1]);
      for (int ax = 0; ax < 3; ax++) solve_spline_axis(ax, n);
      for (int i = 0; i < n; i++) begin
        push_ctrl(pt_at(0, i), pt_at(1, i), pt_at(2, i), KIND_PT, 1'b0);
        push_ctrl(sweep_val[0][i], sweep_val[1][i], sweep_val[2][i], KIND_A, 1'b0);
        push_ctrl(inner_b(0, i, n), inner_b(1, i, n), inner_b(2, i, n), KIND_B, 1'b0);
      end
      push_ctrl(pt_at(0, n), pt_at(1, n), pt_at(2, n), KIND_PT, 1'b1);
    end
    pt_count = 0;
    pt_overflow = 0;
  endtask

  function automatic coord_t rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return coord_t'($urandom);
    if (sel < 8) return coord_t'($urandom_range(0, 2097151)) - 32'sd1048576;
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return 32'shffffffff;
    endcase
  endfunction

  task automatic add_point(coord_t x, coord_t y, coord_t z, logic last, bit drain);
    point_req_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    p.drain = drain;
    point_q.insert(point_q.size(), p);
  endtask

  task automatic add_random_set(int size, bit drain);
    for (int i = 0; i < size; i++)
      add_point(rand_coord(), rand_coord(), rand_coord(), i == size - 1, drain && i == 0);
  endtask

  function automatic int sender_idle_pct();
    if (acc_in < 100) return 0;
    if (acc_in < 200) return 85;
    if (acc_in < 300) return 0;
    return 27;
  endfunction

  function automatic int receiver_stall_pct();
    if (acc_in < 200) return 0;
    if (acc_in < 300) return 85;
    return 27;
  endfunction

  always @(negedge clk) begin
    logic nv;
    point_req_t p;
    nv = in_ch.valid;
    if (rst_n && (!in_ch.valid || in_acc)) begin
      nv = 1'b0;
      if (point_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        if (!point_q[0].drain || ctrl_q.size() == 0) begin
          p = point_q.pop_front();
          in_ch.point_x <= p.x;
          in_ch.point_y <= p.y;
          in_ch.point_z <= p.z;
          in_ch.last_point <= p.last;
          nv = 1'b1;
        end
      end
    end
    in_ch.valid <= nv;
  end

  always @(negedge clk) begin
    if (!held && acc_in >= 330) begin
      held = 1;
      holdoff = 400;
    end
    if (holdoff > 0) begin
      holdoff--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    ctrl_pt_t e;
    in_acc <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      acc_in++;
      predict_ctrl_points(in_ch.point_x, in_ch.point_y, in_ch.point_z, in_ch.last_point);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      acc_out++;
      if (ctrl_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%h y=%h z=%h kind=%0d", $time,
                 out_ch.ctrl_x, out_ch.ctrl_y, out_ch.ctrl_z, out_ch.point_kind);
      end else begin
        e = ctrl_q.pop_front();
        if (out_ch.ctrl_x !== e.x || out_ch.ctrl_y !== e.y || out_ch.ctrl_z !== e.z ||
            out_ch.point_kind !== e.kind || out_ch.overflow !== e.ovf ||
            out_ch.last_out !== e.last) begin
          errors++;
          $display("%0t: mismatch expected x=%h y=%h z=%h kind=%0d ovf=%b last=%b", $time,
                   e.x, e.y, e.z, e.kind, e.ovf, e.last);
          $display("%0t:          actual   x=%h y=%h z=%h kind=%0d ovf=%b last=%b", $time,
                   out_ch.ctrl_x, out_ch.ctrl_y, out_ch.ctrl_z, out_ch.point_kind,
                   out_ch.overflow, out_ch.last_out);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= 20000) begin
      $display("%0t: timeout, no request moved", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int total;
    int r;
    int size;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready = 1'b0;

    add_point(32'sh80000000, 32'sh7fffffff, 32'sh0, 1'b0, 0);
    add_point(32'sh7fffffff, 32'sh80000000, 32'shffffffff, 1'b1, 0);
    add_point(32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1, 0);
    add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0, 0);
    add_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0, 0);
    add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b1, 0);
    for (int i = 0; i < 18; i++)
      add_point(rand_coord(), rand_coord(), rand_coord(), i == 17, 0);
    total = point_q.size();

    add_random_set(4, 1);
    total += 4;
    while (total < 420) begin
      r = $urandom_range(0, 99);
      if (r < 8) size = 1;
      else if (r < 18) size = 2;
      else if (r < 80) size = $urandom_range(3, 6);
      else if (r < 90) size = $urandom_range(7, 16);
      else size = $urandom_range(17, 20);
      add_random_set(size, 0);
      total += size;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (point_q.size() == 0 && !in_ch.valid);
    wait (ctrl_q.size() == 0);
    repeat (1000) @(posedge clk);

    $display("Covered %0d point sets (%0d with dropped points) from %0d points, %0d results.",
             sets_done, ovf_sets, acc_in, acc_out);
    if (errors == 0 && ctrl_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
